// File: rtl/kase_pkg.sv
`timescale 1ns / 1ps
package kase_pkg;

   localparam int MaxSymbols  = 128;
   localparam int MaxKeyBytes = 64;
   localparam int SymAw       = $clog2(MaxSymbols);
   localparam int KeyAw       = $clog2(MaxKeyBytes);

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_LOAD_ALPHA = 2'd0;
   localparam logic [1:0] REQ_LOAD_KEY   = 2'd1;
   localparam logic [1:0] REQ_START      = 2'd2;
   localparam logic [1:0] REQ_DATA       = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_ALPHA = 2'd1;
   localparam logic [1:0] ST_NO_START  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_MAX_LINE     = 2'd2;

   // Source of an emitted result beat.
   localparam logic [2:0] SRC_SALT = 3'd0;
   localparam logic [2:0] SRC_ERR1 = 3'd1;
   localparam logic [2:0] SRC_ERR2 = 3'd2;
   localparam logic [2:0] SRC_WORK = 3'd3;
   localparam logic [2:0] SRC_NL   = 3'd4;

   localparam logic [7:0] CHAR_LF   = 8'd10;
   localparam logic [7:0] CHAR_CR   = 8'd13;
   localparam logic [2:0] SALT_LEN  = 3'd5;

   // Key entries after reset: "0910".
   localparam logic [7:0] KEY_RESET [4] = '{8'h30, 8'h39, 8'h31, 8'h30};

   typedef struct packed {
      logic       accept;
      logic       chk_start;
      logic       chk_rd;
      logic       chk_eval;
      logic       open_msg;
      logic       close_msg;
      logic       emit;
      logic [2:0] emit_src;
      logic       emit_last;
      logic       salt_next;
      logic       sel_data;
      logic       rd_sym;
      logic       esc_done;
      logic       sym_done;
      logic       sh_init;
      logic       sh_salt;
      logic       sh_key_rd;
      logic       sh_mod;
      logic       sh_rd;
      logic       sh_w1;
      logic       sh_w2;
   } kase_cmd_type;

   typedef struct packed {
      logic msg_open;
      logic chk_last;
      logic chk_ok;
      logic out_free;
      logic esc;
      logic nl;
      logic sss_wrap;
      logic salt_last;
      logic sh_skip;
      logic sh_end;
   } kase_stat_type;

endpackage

// File: rtl/kase_ctrl.sv
`timescale 1ns / 1ps
module kase_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic [1:0]             req_type,
   output logic                   req_tready,
   input  kase_pkg::kase_stat_type stat,
   output kase_pkg::kase_cmd_type  cmd
);
   import kase_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CHK_RD  = 5'd1;
   localparam logic [4:0] S_CHK_EV  = 5'd2;
   localparam logic [4:0] S_CHK_END = 5'd3;
   localparam logic [4:0] S_SALT    = 5'd4;
   localparam logic [4:0] S_ERR1    = 5'd5;
   localparam logic [4:0] S_ERR2    = 5'd6;
   localparam logic [4:0] S_DSEL    = 5'd7;
   localparam logic [4:0] S_DRD     = 5'd8;
   localparam logic [4:0] S_DEMIT   = 5'd9;
   localparam logic [4:0] S_NL      = 5'd10;
   localparam logic [4:0] S_DNEXT   = 5'd11;
   localparam logic [4:0] S_SH_INIT = 5'd12;
   localparam logic [4:0] S_SH_KEY  = 5'd13;
   localparam logic [4:0] S_SH_MOD  = 5'd14;
   localparam logic [4:0] S_SH_RD   = 5'd15;
   localparam logic [4:0] S_SH_W1   = 5'd16;
   localparam logic [4:0] S_SH_W2   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       ret_data_ff, ret_data_in;
   logic       salt_mode_ff, salt_mode_in;
   logic       esc_ff, esc_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      ret_data_in  = ret_data_ff;
      salt_mode_in = salt_mode_ff;
      esc_in       = esc_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_type)
                  REQ_START: begin
                     cmd.chk_start = 1'b1;
                     state_in      = S_CHK_RD;
                  end
                  REQ_DATA: begin
                     state_in = stat.msg_open ? S_DSEL : S_ERR2;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CHK_RD: begin
            cmd.chk_rd = 1'b1;
            state_in   = S_CHK_EV;
         end
         S_CHK_EV: begin
            cmd.chk_eval = 1'b1;
            state_in     = stat.chk_last ? S_CHK_END : S_CHK_RD;
         end
         S_CHK_END: begin
            if (stat.chk_ok) begin
               cmd.open_msg = 1'b1;
               state_in     = S_SALT;
            end else begin
               cmd.close_msg = 1'b1;
               state_in      = S_ERR1;
            end
         end
         S_SALT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_SALT;
               cmd.emit_last = stat.salt_last;
               cmd.salt_next = 1'b1;
               if (stat.salt_last) begin
                  salt_mode_in = 1'b1;
                  ret_data_in  = 1'b0;
                  state_in     = S_SH_INIT;
               end
            end
         end
         S_ERR1: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_ERR1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ERR2: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_ERR2;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DSEL: begin
            cmd.sel_data = 1'b1;
            esc_in       = stat.esc;
            state_in     = S_DRD;
         end
         S_DRD: begin
            cmd.rd_sym = 1'b1;
            state_in   = S_DEMIT;
         end
         S_DEMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_WORK;
               cmd.emit_last = !esc_ff && !stat.nl;
               state_in      = stat.nl ? S_NL : S_DNEXT;
            end
         end
         S_NL: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_NL;
               cmd.emit_last = !esc_ff;
               state_in      = S_DNEXT;
            end
         end
         S_DNEXT: begin
            salt_mode_in = 1'b0;
            if (esc_ff) begin
               cmd.esc_done = 1'b1;
               ret_data_in  = 1'b1;
               state_in     = S_SH_INIT;
            end else begin
               cmd.sym_done = 1'b1;
               ret_data_in  = 1'b0;
               state_in     = stat.sss_wrap ? S_SH_INIT : S_IDLE;
            end
         end
         S_SH_INIT: begin
            cmd.sh_init = 1'b1;
            cmd.sh_salt = salt_mode_ff;
            if (stat.sh_skip) begin
               state_in = ret_data_ff ? S_DSEL : S_IDLE;
            end else begin
               state_in = S_SH_KEY;
            end
         end
         S_SH_KEY: begin
            cmd.sh_key_rd = 1'b1;
            state_in      = S_SH_MOD;
         end
         S_SH_MOD: begin
            cmd.sh_mod  = 1'b1;
            cmd.sh_salt = salt_mode_ff;
            state_in    = S_SH_RD;
         end
         S_SH_RD: begin
            cmd.sh_rd = 1'b1;
            state_in  = S_SH_W1;
         end
         S_SH_W1: begin
            cmd.sh_w1 = 1'b1;
            state_in  = S_SH_W2;
         end
         S_SH_W2: begin
            cmd.sh_w2   = 1'b1;
            cmd.sh_salt = salt_mode_ff;
            if (stat.sh_end) begin
               state_in = ret_data_ff ? S_DSEL : S_IDLE;
            end else begin
               state_in = S_SH_KEY;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_data_ff  <= 1'b0;
         salt_mode_ff <= 1'b0;
         esc_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_data_ff  <= ret_data_in;
         salt_mode_ff <= salt_mode_in;
         esc_ff       <= esc_in;
      end
   end

endmodule

// File: rtl/kase_dpath.sv
`timescale 1ns / 1ps
module kase_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [9:0]              csr_data,
   input  logic [1:0]              req_type,
   input  logic [6:0]              req_index,
   input  logic [7:0]              req_value,
   input  logic [39:0]             req_salt,
   input  kase_pkg::kase_cmd_type  cmd,
   output kase_pkg::kase_stat_type stat,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import kase_pkg::*;

   // Configuration registers.
   logic [7:0] symbol_count_ff;
   logic [6:0] key_length_ff;
   logic [9:0] max_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= 8'd92;
         key_length_ff   <= 7'd4;
         max_line_ff     <= 10'd80;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SYMBOL_COUNT: symbol_count_ff <= csr_data[7:0];
            CSR_KEY_LENGTH:   key_length_ff   <= csr_data[6:0];
            CSR_MAX_LINE:     max_line_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped alphabet size and key length.
   logic [7:0] n_eff;
   logic [7:0] n_m1;
   logic [6:0] klen_user;
   assign n_eff = (symbol_count_ff < 8'd16) ? 8'd16 :
                  (symbol_count_ff > 8'(MaxSymbols)) ? 8'(MaxSymbols) : symbol_count_ff;
   assign n_m1  = n_eff - 8'd1;
   assign klen_user = (key_length_ff > 7'(MaxKeyBytes)) ? 7'(MaxKeyBytes) : key_length_ff;

   // Memories.
   logic [7:0] init_mem [MaxSymbols];
   logic [7:0] work_mem [MaxSymbols];
   logic [7:0] key_mem  [MaxKeyBytes];
   logic [3:0] key_wr_ff;

   // Per-item registers.
   logic [7:0]       val_ff;
   logic [39:0]      salt_ff;
   logic [SymAw-1:0] i_ff;
   logic [2:0]       salt_j_ff;
   logic [255:0]     seen_ff;
   logic             ok_ff;
   logic [7:0]       init_rd_ff;
   logic [SymAw-1:0] addr_ff;
   logic [7:0]       rd_a_ff;
   logic [7:0]       rd_b_ff;
   logic [7:0]       key_rd_ff;
   logic [KeyAw-1:0] pos_ff;
   logic [6:0]       klen_ff;
   logic [1:0]       run_ff;
   logic [1:0]       runs_last_ff;
   logic [SymAw-1:0] t_ff;
   logic [9:0]       lp_ff;
   logic [6:0]       sss_ff;
   logic             open_ff;

   // The copy walks the whole table; only entries in use are checked.
   logic chk_in_use;
   logic chk_end;
   assign chk_in_use = ({1'b0, i_ff} <= n_m1);
   assign chk_end    = (i_ff == SymAw'(MaxSymbols - 1));

   // Load writes and payload capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         val_ff  <= req_value;
         salt_ff <= req_salt;
         if (req_type == REQ_LOAD_ALPHA) begin
            init_mem[req_index[SymAw-1:0]] <= req_value;
         end
         if (req_type == REQ_LOAD_KEY && req_index < 7'(MaxKeyBytes)) begin
            key_mem[req_index[KeyAw-1:0]] <= req_value;
         end
      end else if (cmd.esc_done) begin
         val_ff <= val_ff - n_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_wr_ff <= '0;
      end else if (cmd.accept && req_type == REQ_LOAD_KEY && req_index < 7'd4) begin
         key_wr_ff[req_index[1:0]] <= 1'b1;
      end
   end

   // Alphabet check walk.
   always_ff @(posedge clock) begin
      if (cmd.chk_rd) begin
         init_rd_ff <= init_mem[i_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.chk_start) begin
         seen_ff <= '0;
         ok_ff   <= 1'b1;
      end else if (cmd.chk_eval && chk_in_use) begin
         seen_ff[init_rd_ff] <= 1'b1;
         if (init_rd_ff == CHAR_LF || init_rd_ff == CHAR_CR || seen_ff[init_rd_ff]) begin
            ok_ff <= 1'b0;
         end
      end
   end

   // Shuffle: key byte fetch and target index.
   logic [7:0]  key_byte;
   logic [11:0] rem;
   logic [6:0]  klen_sel;
   logic [5:0]  half;

   assign key_byte = cmd.sh_salt ? salt_ff[8*pos_ff[2:0] +: 8] : key_rd_ff;
   assign klen_sel = cmd.sh_salt ? 7'(SALT_LEN) : klen_user;
   assign half     = klen_sel[6:1];

   always_comb begin
      rem = 12'({1'b0, i_ff}) + 12'(key_byte);
      for (int b = 4; b >= 0; b--) begin
         if (rem >= (12'(n_eff) << b)) begin
            rem = rem - (12'(n_eff) << b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sh_key_rd) begin
         if (pos_ff < KeyAw'(4) && !key_wr_ff[pos_ff[1:0]]) begin
            key_rd_ff <= KEY_RESET[pos_ff[1:0]];
         end else begin
            key_rd_ff <= key_mem[pos_ff];
         end
      end
      if (cmd.sh_mod) begin
         t_ff <= rem[SymAw-1:0];
      end
   end

   // Working alphabet: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.chk_eval) begin
         work_mem[i_ff] <= init_rd_ff;
      end else if (cmd.sh_w1) begin
         work_mem[i_ff] <= rd_b_ff;
      end else if (cmd.sh_w2) begin
         work_mem[t_ff] <= rd_a_ff;
      end
      if (cmd.sh_rd) begin
         rd_a_ff <= work_mem[i_ff];
         rd_b_ff <= work_mem[t_ff];
      end else if (cmd.rd_sym) begin
         rd_a_ff <= work_mem[addr_ff];
      end
   end

   // Data byte: escape decision.
   logic esc;
   assign esc = ({1'b0, val_ff} >= {1'b0, n_m1});

   always_ff @(posedge clock) begin
      if (cmd.sel_data) begin
         addr_ff <= esc ? n_m1[SymAw-1:0] : val_ff[SymAw-1:0];
      end
   end

   // Walk counters for check and shuffle.
   logic i_last;
   assign i_last = ({1'b0, i_ff} == n_m1);

   always_ff @(posedge clock) begin
      if (cmd.chk_start || cmd.sh_init) begin
         i_ff   <= '0;
         pos_ff <= '0;
         run_ff <= '0;
         klen_ff <= klen_sel;
         runs_last_ff <= ({3'b0, half} >= {n_eff, 1'b0}) ? 2'd2 :
                         ({2'b0, half} >= n_eff) ? 2'd1 : 2'd0;
      end else if (cmd.chk_eval) begin
         i_ff <= i_ff + SymAw'(1);
      end else if (cmd.sh_w2) begin
         if (i_last) begin
            i_ff   <= '0;
            run_ff <= run_ff + 2'd1;
         end else begin
            i_ff <= i_ff + SymAw'(1);
         end
         if (7'(pos_ff) + 7'd1 >= klen_ff) begin
            pos_ff <= '0;
         end else begin
            pos_ff <= pos_ff + KeyAw'(1);
         end
      end
   end

   // Line position, symbol count since shuffle and message state.
   logic [9:0] lp_next;
   logic       nl;
   assign lp_next = lp_ff + 10'd1;
   assign nl      = (max_line_ff != 10'd0) && (lp_next >= max_line_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff   <= '0;
         sss_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         if (cmd.open_msg) begin
            lp_ff   <= 10'd5;
            sss_ff  <= '0;
            open_ff <= 1'b1;
         end else if (cmd.close_msg) begin
            open_ff <= 1'b0;
         end
         if (cmd.emit && cmd.emit_src == SRC_WORK) begin
            lp_ff <= lp_next;
         end else if (cmd.emit && cmd.emit_src == SRC_NL) begin
            lp_ff <= '0;
         end
         if (cmd.esc_done) begin
            sss_ff <= '0;
         end else if (cmd.sym_done) begin
            sss_ff <= stat.sss_wrap ? 7'd0 : sss_ff + 7'd1;
         end
      end
   end

   // Salt beat counter.
   always_ff @(posedge clock) begin
      if (cmd.open_msg) begin
         salt_j_ff <= '0;
      end else if (cmd.salt_next) begin
         salt_j_ff <= salt_j_ff + 3'd1;
      end
   end

   // Result register.
   logic       out_valid_ff;
   logic [7:0] out_sym_ff;
   logic [1:0] out_status_ff;
   logic       out_last_ff;
   logic [7:0] emit_sym;
   logic [1:0] emit_status;

   always_comb begin
      emit_sym    = 8'd0;
      emit_status = ST_OK;
      unique case (cmd.emit_src)
         SRC_SALT: emit_sym = salt_ff[8*salt_j_ff +: 8];
         SRC_ERR1: emit_status = ST_BAD_ALPHA;
         SRC_ERR2: emit_status = ST_NO_START;
         SRC_WORK: emit_sym = rd_a_ff;
         SRC_NL:   emit_sym = CHAR_LF;
         default:  emit_sym = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_sym_ff    <= emit_sym;
         out_status_ff <= emit_status;
         out_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   // Status back to the controller.
   always_comb begin
      stat           = '0;
      stat.msg_open  = open_ff;
      stat.chk_last  = chk_end;
      stat.chk_ok    = ok_ff;
      stat.out_free  = !out_valid_ff || rsp_tready;
      stat.esc       = esc;
      stat.nl        = nl;
      stat.sss_wrap  = ({1'b0, sss_ff} + 8'd1 >= n_eff);
      stat.salt_last = (salt_j_ff == SALT_LEN - 3'd1);
      stat.sh_skip   = (klen_sel == 7'd0);
      stat.sh_end    = i_last && (run_ff == runs_last_ff);
   end

endmodule

// File: rtl/keyed_alphabet_shuffle_encoder.sv
`timescale 1ns / 1ps
// Keyed alphabet shuffle encoder.
// Input beats on req_* carry a kind in req_tuser: alphabet load, key load,
// message start (with five salt bytes) or data byte. Loads give no result. A
// start walks the whole alphabet table to check the entries in use and copy
// the table to the working table; if the check passes it emits the five salt
// bytes, then shuffles the table, else it emits an error beat. A data byte
// emits one symbol (plus escapes and newlines) and may trigger reshuffles;
// without an open message it emits an error beat instead. Shuffles swap
// entries through the single-write-port working table; one item is processed
// at a time.
// Result beats leave on rsp_* from an output register; rsp_tlast marks the
// final beat of an item and rsp_tuser carries the status. When the receiver
// stalls the block holds that beat and waits. The csr_* port writes the
// symbol count, key length and line length; write it only while idle.
// Reset clears the message state and line position, restores the default
// configuration and the default key; alphabets must be loaded before a start.
module keyed_alphabet_shuffle_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // index[6:0], value[14:7], salt[54:15], zero[55]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // symbol[7:0]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import kase_pkg::*;

   kase_cmd_type  cmd;
   kase_stat_type stat;

   assign csr_ready = 1'b1;

   kase_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kase_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_type   (req_tuser),
      .req_index  (req_tdata[6:0]),
      .req_value  (req_tdata[14:7]),
      .req_salt   (req_tdata[54:15]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import kase_pkg::*;

   localparam int CycleLimit = 6000000;
   localparam int SettleCycles = 6000;

   typedef struct {
      logic [1:0]  kind;
      logic [6:0]  idx;
      logic [7:0]  val;
      logic [39:0] salt;
   } req_item_type;

   typedef struct {
      logic [7:0] symbol;
      logic [1:0] status;
      logic       last;
   } enc_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   keyed_alphabet_shuffle_encoder dut (.*);

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Encoder mirror state.
   logic [7:0] init_alpha [MaxSymbols];
   logic [7:0] work_alpha [MaxSymbols];
   logic [7:0] key_mem [MaxKeyBytes];
   logic [7:0] sym_count_reg = 8'd92;
   logic [6:0] key_len_reg = 7'd4;
   logic [9:0] line_max_reg = 10'd80;
   int         since_shuffle = 0;
   logic [9:0] line_pos = '0;
   logic       msg_open = 1'b0;

   req_item_type pending_reqs [$];
   enc_beat_type expected_beats [$];
   int         fails = 0;
   int         cycles = 0;
   logic       calm = 1'b0;

   // Stimulus-side copy of the alphabet, kept free of duplicates.
   logic [7:0] alpha_plan [MaxSymbols];
   int         cur_n = 92;

   function automatic int table_len();
      int n;
      n = sym_count_reg;
      if (n < 16) n = 16;
      if (n > MaxSymbols) n = MaxSymbols;
      return n;
   endfunction

   task automatic permute_table(input logic [7:0] k [MaxKeyBytes], input int klen,
                                input int n);
      int runs;
      int pos;
      int t;
      logic [7:0] c;
      if (klen == 0) return;
      runs = (klen / 2) / n + 1;
      pos = 0;
      for (int r = 0; r < runs; r++) begin
         for (int i = 0; i < n; i++) begin
            t = (i + k[pos]) % n;
            c = work_alpha[i];
            work_alpha[i] = work_alpha[t];
            work_alpha[t] = c;
            pos++;
            if (pos >= klen) pos = 0;
         end
      end
   endtask

   task automatic add_beat(input logic [7:0] sym, input logic [1:0] st);
      enc_beat_type b;
      b.symbol = sym;
      b.status = st;
      b.last = 1'b0;
      expected_beats.push_back(b);
   endtask

   task automatic add_symbol(input logic [7:0] sym);
      add_beat(sym, ST_OK);
      line_pos = line_pos + 10'd1;
      if (line_max_reg != 0 && line_pos >= line_max_reg) begin
         add_beat(CHAR_LF, ST_OK);
         line_pos = '0;
      end
   endtask

   // Predict the result beats of one accepted request.
   task automatic predict_encode(input req_item_type it);
      int n;
      int klen;
      int v;
      logic ok;
      logic [7:0] sk [MaxKeyBytes];
      n = table_len();
      klen = (key_len_reg > MaxKeyBytes) ? MaxKeyBytes : key_len_reg;
      case (it.kind)
         REQ_LOAD_ALPHA: begin
            init_alpha[it.idx] = it.val;
         end
         REQ_LOAD_KEY: begin
            if (it.idx < MaxKeyBytes) key_mem[it.idx[KeyAw-1:0]] = it.val;
         end
         REQ_START: begin
            ok = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (init_alpha[i] == CHAR_LF || init_alpha[i] == CHAR_CR) ok = 1'b0;
               for (int j = 0; j < i; j++)
                  if (init_alpha[j] == init_alpha[i]) ok = 1'b0;
            end
            if (!ok) begin
               msg_open = 1'b0;
               add_beat(8'd0, ST_BAD_ALPHA);
            end else begin
               work_alpha = init_alpha;
               for (int i = 0; i < MaxKeyBytes; i++) sk[i] = 8'd0;
               for (int i = 0; i < 5; i++) begin
                  sk[i] = it.salt[8*i +: 8];
                  add_beat(sk[i], ST_OK);
               end
               line_pos = 10'd5;
               since_shuffle = 0;
               msg_open = 1'b1;
               permute_table(sk, 5, n);
            end
         end
         default: begin
            if (!msg_open) begin
               add_beat(8'd0, ST_NO_START);
            end else begin
               v = it.val;
               while (v >= n - 1) begin
                  add_symbol(work_alpha[n-1]);
                  v -= n - 1;
                  permute_table(key_mem, klen, n);
                  since_shuffle = 0;
               end
               add_symbol(work_alpha[v]);
               since_shuffle++;
               if (since_shuffle >= n) begin
                  permute_table(key_mem, klen, n);
                  since_shuffle = 0;
               end
            end
         end
      endcase
      if (it.kind == REQ_START || it.kind == REQ_DATA)
         expected_beats[expected_beats.size()-1].last = 1'b1;
   endtask

   // Request driver.
   req_item_type drv_item;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            drv_item = pending_reqs.pop_front();
            req_tdata <= {1'b0, drv_item.salt, drv_item.val, drv_item.idx};
            req_tuser <= drv_item.kind;
            req_tvalid <= 1'b1;
            predict_encode(drv_item);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor and back-pressure.
   enc_beat_type mon_exp;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat symbol %0d", rsp_tdata);
            fails++;
         end else begin
            mon_exp = expected_beats.pop_front();
            if (rsp_tdata !== mon_exp.symbol) begin
               $error("symbol expected %0d actual %0d", mon_exp.symbol, rsp_tdata);
               fails++;
            end
            if (rsp_tuser !== mon_exp.status) begin
               $error("status expected %0d actual %0d", mon_exp.status, rsp_tuser);
               fails++;
            end
            if (rsp_tlast !== mon_exp.last) begin
               $error("last expected %0d actual %0d", mon_exp.last, rsp_tlast);
               fails++;
            end
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= 27);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] kind, input logic [6:0] idx,
                           input logic [7:0] val, input logic [39:0] salt);
      req_item_type it;
      it.kind = kind;
      it.idx = idx;
      it.val = val;
      it.salt = salt;
      pending_reqs.push_back(it);
   endtask

   function automatic logic [39:0] rand_salt();
      return {8'($urandom_range(255)), $urandom()};
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [9:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SYMBOL_COUNT: sym_count_reg = data[7:0];
         CSR_KEY_LENGTH:   key_len_reg = data[6:0];
         default:          line_max_reg = data;
      endcase
   endtask

   // Build a fresh alphabet of distinct characters without CR or LF.
   task automatic load_fresh_alphabet();
      logic [7:0] pool [$];
      int j;
      logic [7:0] c;
      for (int v = 0; v < 256; v++)
         if (v != CHAR_LF && v != CHAR_CR) pool.push_back(v[7:0]);
      for (int i = 0; i < MaxSymbols; i++) begin
         j = $urandom_range(pool.size() - 1 - i) + i;
         c = pool[i];
         pool[i] = pool[j];
         pool[j] = c;
         alpha_plan[i] = pool[i];
         push_req(REQ_LOAD_ALPHA, i[6:0], pool[i], rand_salt());
      end
   endtask

   // A broken start: one entry made bad, then restored and a good start.
   task automatic queue_bad_start();
      int a;
      int b;
      int r;
      logic [7:0] bad;
      a = $urandom_range(1, 15);
      b = $urandom_range(0, a - 1);
      r = $urandom_range(2);
      bad = (r == 0) ? CHAR_LF : (r == 1) ? CHAR_CR : alpha_plan[b];
      push_req(REQ_LOAD_ALPHA, a[6:0], bad, rand_salt());
      push_req(REQ_START, 7'($urandom_range(127)), 8'($urandom_range(255)), rand_salt());
      push_req(REQ_DATA, 7'($urandom_range(127)), 8'($urandom_range(255)), rand_salt());
      push_req(REQ_LOAD_ALPHA, a[6:0], alpha_plan[a], rand_salt());
      push_req(REQ_START, 7'($urandom_range(127)), 8'($urandom_range(255)), rand_salt());
   endtask

   task automatic queue_phase(input int n_items);
      int made;
      int r;
      int a;
      int b;
      logic [7:0] c;
      logic [6:0] ki;
      made = 1;
      push_req(REQ_START, 7'($urandom_range(127)), 8'($urandom_range(255)), rand_salt());
      while (made < n_items) begin
         r = $urandom_range(99);
         if (r < 6) begin
            ki = 7'($urandom_range(127));
            push_req(REQ_LOAD_KEY, ki, 8'($urandom_range(255)), rand_salt());
            if (ki < MaxKeyBytes) made++;
         end else if (r < 9) begin
            a = $urandom_range(MaxSymbols - 1);
            b = $urandom_range(MaxSymbols - 1);
            c = alpha_plan[a];
            alpha_plan[a] = alpha_plan[b];
            alpha_plan[b] = c;
            push_req(REQ_LOAD_ALPHA, a[6:0], alpha_plan[a], rand_salt());
            push_req(REQ_LOAD_ALPHA, b[6:0], alpha_plan[b], rand_salt());
            made += 2;
         end else if (r < 12) begin
            queue_bad_start();
            made += 5;
         end else if (r < 14) begin
            push_req(REQ_START, 7'($urandom_range(127)), 8'($urandom_range(255)),
                     rand_salt());
            made++;
         end else begin
            push_req(REQ_DATA, 7'($urandom_range(127)),
                     (r < 65) ? 8'($urandom_range(cur_n - 2)) : 8'($urandom_range(255)),
                     rand_salt());
            made++;
         end
      end
   endtask

   // Register settings per phase: symbol count, key length, line length.
   int ph_sc [7] = '{92, 16, 128, 5, 200, 255, 40};
   int ph_kl [7] = '{4, 64, 0, 127, 1, 33, 2};
   int ph_ml [7] = '{80, 1, 1023, 0, 80, 7, 5};

   initial begin
      for (int i = 0; i < MaxKeyBytes; i++) key_mem[i] = 8'd0;
      key_mem[0] = KEY_RESET[0];
      key_mem[1] = KEY_RESET[1];
      key_mem[2] = KEY_RESET[2];
      key_mem[3] = KEY_RESET[3];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: data before any start, then setup.
      push_req(REQ_DATA, 7'd127, 8'd255, 40'hFF_FFFF_FFFF);
      load_fresh_alphabet();
      for (int i = 0; i < MaxKeyBytes; i++)
         push_req(REQ_LOAD_KEY, i[6:0], 8'($urandom_range(255)), rand_salt());
      push_req(REQ_LOAD_KEY, 7'd100, 8'hFF, 40'd0);
      // Duplicate entry, CR and LF each reject the alphabet.
      push_req(REQ_LOAD_ALPHA, 7'd3, alpha_plan[0], 40'd0);
      push_req(REQ_START, 7'd0, 8'd0, 40'd0);
      push_req(REQ_DATA, 7'd0, 8'd1, 40'd0);
      push_req(REQ_LOAD_ALPHA, 7'd3, CHAR_CR, 40'd0);
      push_req(REQ_START, 7'd0, 8'd0, 40'd0);
      push_req(REQ_LOAD_ALPHA, 7'd91, CHAR_LF, 40'd0);
      push_req(REQ_LOAD_ALPHA, 7'd3, alpha_plan[3], 40'd0);
      push_req(REQ_START, 7'd0, 8'd0, 40'd0);
      push_req(REQ_LOAD_ALPHA, 7'd91, alpha_plan[91], 40'd0);
      push_req(REQ_START, 7'd127, 8'd255, 40'hFF_FFFF_FFFF);
      push_req(REQ_DATA, 7'd0, 8'd0, 40'd0);
      push_req(REQ_DATA, 7'd0, 8'd255, 40'd0);
      push_req(REQ_DATA, 7'd0, 8'd90, 40'd0);
      push_req(REQ_DATA, 7'd0, 8'd91, 40'd0);
      push_req(REQ_START, 7'd0, 8'd0, 40'd0);
      push_req(REQ_DATA, 7'd0, 8'd0, 40'd0);
      wait_idle();

      // Random phases, one per register setting.
      for (int p = 0; p < 7; p++) begin
         calm = (p == 2);
         write_csr(CSR_SYMBOL_COUNT, ph_sc[p][9:0]);
         write_csr(CSR_KEY_LENGTH, ph_kl[p][9:0]);
         write_csr(CSR_MAX_LINE, ph_ml[p][9:0]);
         cur_n = table_len();
         queue_phase(31);
         wait_idle();
      end

      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/kase_pkg.sv
rtl/kase_ctrl.sv
rtl/kase_dpath.sv
rtl/keyed_alphabet_shuffle_encoder.sv
dv/tb.sv
